// File: design/assert_macros.svh
// assertion macros for the encoder design
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error("fail");
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error("fail");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

// File: design/crgr_pkg.sv
// shared types and constants for the context rank golomb rice encoder
// no dependencies
package crgr_pkg;
	localparam int ADAPT_INTERVAL = 256;
	localparam int COUNT_BITS = 32;
	localparam int RCNT_W = $clog2(ADAPT_INTERVAL + 1);
	localparam int RSUM_W = RCNT_W + 8;
	localparam int ADDR_W = 16;
	localparam int QDEPTH = 2;
	localparam logic [2:0] K_RESET = 3'd3;
	localparam logic [8:0] END_CODE = 9'd256;

	typedef struct packed {
		logic action;
		logic [7:0] symbol;
	} in_item_t;

	typedef struct packed {
		logic [31:0] packed_word;
		logic last_of_item;
		logic stream_end;
	} out_item_t;

	// code job from front to back
	typedef struct packed {
		logic [8:0] value;
		logic [2:0] k;
		logic is_end;
	} job_t;

	typedef enum logic [3:0] {
		F_CLEAR, F_IDLE, F_RD_RANK, F_WT_RANK, F_SCAN_RD, F_SCAN_WT, F_SCAN_CNT,
		F_SWAP_RD, F_SWAP_WT, F_WRITE, F_PUSH
	} fstate_t;
endpackage

// File: design/crgr_ram.sv
// generic single port ram with registered read
// no dependencies
module crgr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic clk,
	input  logic we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem[addr] <= wdata;
		rdata <= mem[addr];
	end
endmodule

// File: design/crgr_front.sv
// front: context model lookup, rank update and k adaptation
// depends on crgr_pkg and crgr_ram
module crgr_front import crgr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  in_item_t in_data,
	output logic job_valid,
	input  logic job_ready,
	output job_t job_data
);
	fstate_t st_q, st_d;
	logic [ADDR_W-1:0] clr_q;
	logic [7:0] ctx_q, sym_q, rank_q, tgt_q, d_q;
	logic [COUNT_BITS-1:0] f_q;
	logic [2:0] k_q;
	logic [RSUM_W-1:0] sum_q;
	logic [RCNT_W-1:0] cnt_q;

	logic fwe, r2we, s2we;
	logic [ADDR_W-1:0] faddr, r2addr, s2addr;
	logic [COUNT_BITS-1:0] fwd, frd;
	logic [7:0] r2wd, r2rd, s2wd, s2rd;
	logic [ADDR_W-1:0] base;
	logic adapt_now;
	logic [2:0] k_new;

	crgr_ram #(.WIDTH(COUNT_BITS), .DEPTH(65536)) u_freq (.clk, .we(fwe), .addr(faddr),
		.wdata(fwd), .rdata(frd));
	crgr_ram #(.WIDTH(8), .DEPTH(65536)) u_r2s (.clk, .we(r2we), .addr(r2addr),
		.wdata(r2wd), .rdata(r2rd));
	crgr_ram #(.WIDTH(8), .DEPTH(65536)) u_s2r (.clk, .we(s2we), .addr(s2addr),
		.wdata(s2wd), .rdata(s2rd));

	assign base = {ctx_q, 8'd0};
	assign adapt_now = (cnt_q == RCNT_W'(ADAPT_INTERVAL));

	// floor of log2 of the window mean
	always_comb begin
		k_new = 3'd0;
		for (int i = 1; i < 8; i++)
			if ((RSUM_W'(ADAPT_INTERVAL) << i) <= sum_q) k_new = 3'(i);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= F_CLEAR;
			clr_q <= '0;
			ctx_q <= '0;
			k_q <= K_RESET;
			sum_q <= '0;
			cnt_q <= '0;
		end else begin
			st_q <= st_d;
			if (st_q == F_CLEAR) clr_q <= clr_q + 1'b1;
			if (st_q == F_IDLE && in_valid && in_ready && in_data.action) ctx_q <= '0;
			if (st_q == F_PUSH && job_ready) begin
				if (adapt_now) begin
					k_q <= k_new;
					sum_q <= RSUM_W'(rank_q);
					cnt_q <= RCNT_W'(1);
				end else begin
					sum_q <= sum_q + RSUM_W'(rank_q);
					cnt_q <= cnt_q + 1'b1;
				end
				ctx_q <= sym_q;
			end
		end
	end

	// per-item registers
	always_ff @(posedge clk) begin
		case (st_q)
			F_IDLE: sym_q <= in_data.symbol;
			F_WT_RANK: begin
				rank_q <= s2rd;
				tgt_q <= s2rd;
				f_q <= (frd == '1) ? frd : frd + 1'b1;
			end
			F_SCAN_CNT: if (f_q > frd) tgt_q <= tgt_q - 1'b1;
			F_SWAP_WT: d_q <= r2rd;
			default: ;
		endcase
	end

	// swap writes: r2s[ic]=d and s2r[c]=target, then r2s[target]=c and s2r[d]=ic
	always_comb begin
		st_d = st_q;
		fwe = 1'b0; r2we = 1'b0; s2we = 1'b0;
		faddr = base | ADDR_W'(sym_q);
		r2addr = base | ADDR_W'(tgt_q);
		s2addr = base | ADDR_W'(sym_q);
		fwd = f_q; r2wd = sym_q; s2wd = rank_q;
		in_ready = 1'b0;
		job_valid = 1'b0;
		job_data.value = {1'b0, rank_q};
		job_data.k = k_q;
		job_data.is_end = 1'b0;
		case (st_q)
			F_CLEAR: begin
				faddr = clr_q; r2addr = clr_q; s2addr = clr_q;
				fwe = 1'b1; r2we = 1'b1; s2we = 1'b1;
				fwd = '0; r2wd = clr_q[7:0]; s2wd = clr_q[7:0];
				if (clr_q == '1) st_d = F_IDLE;
			end
			F_IDLE: begin
				in_ready = job_ready;
				job_valid = in_valid && in_data.action;
				job_data.value = END_CODE;
				job_data.is_end = 1'b1;
				if (in_valid && job_ready && !in_data.action) st_d = F_RD_RANK;
			end
			F_RD_RANK: st_d = F_WT_RANK;
			F_WT_RANK: st_d = F_SCAN_RD;
			F_SCAN_RD: begin
				r2addr = base | ADDR_W'(tgt_q - 8'd1);
				st_d = (tgt_q == 8'd0) ? F_SWAP_RD : F_SCAN_WT;
			end
			F_SCAN_WT: begin
				faddr = base | ADDR_W'(r2rd);
				st_d = F_SCAN_CNT;
			end
			F_SCAN_CNT: begin
				if (f_q > frd) st_d = F_SCAN_RD;
				else st_d = F_SWAP_RD;
			end
			F_SWAP_RD: begin
				fwe = 1'b1;
				st_d = F_SWAP_WT;
			end
			F_SWAP_WT: begin
				r2we = 1'b1; r2addr = base | ADDR_W'(rank_q); r2wd = r2rd;
				s2we = 1'b1; s2wd = tgt_q;
				st_d = F_WRITE;
			end
			F_WRITE: begin
				r2we = 1'b1;
				s2we = 1'b1; s2addr = base | ADDR_W'(d_q);
				st_d = F_PUSH;
			end
			F_PUSH: begin
				job_valid = 1'b1;
				if (job_ready) st_d = F_IDLE;
			end
			default: st_d = F_IDLE;
		endcase
	end
endmodule

// File: design/crgr_back.sv
// back: golomb rice bit packer into 32-bit words
// depends on crgr_pkg
module crgr_back import crgr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic job_valid,
	output logic job_ready,
	input  job_t job_data,
	output logic out_valid,
	input  logic out_ready,
	output out_item_t out_data
);
	logic busy_q, busy_d;
	job_t j_q, j_d;
	logic [8:0] qv_q, qv_d;
	logic [8:0] len_q, len_d;
	logic [8:0] pos_q, pos_d;
	logic flush_q, flush_d;
	logic [31:0] buf_q, buf_d;
	logic [4:0] fill_q, fill_d;
	logic ov_q, ov_d;
	out_item_t od_q, od_d;
	logic bit_v, last_bit, last_word, stall;
	logic [31:0] nbuf;
	logic [8:0] qv_in;

	assign job_ready = !busy_q;
	assign out_valid = ov_q;
	assign out_data = od_q;
	assign qv_in = job_data.value >> job_data.k;

	always_comb begin
		if (pos_q < qv_q) bit_v = 1'b0;
		else if (pos_q == qv_q) bit_v = 1'b1;
		else bit_v = j_q.value[3'(pos_q - qv_q - 9'd1)];
		last_bit = (pos_q + 9'd1 == len_q);
		// a non-end item has no further word once fewer than 32 bits follow this one
		last_word = j_q.is_end ? last_bit : (len_q - pos_q <= 9'd32);
		nbuf = buf_q | (32'(bit_v) << fill_q);
		stall = ov_q && !out_ready;
	end

	always_comb begin
		busy_d = busy_q;
		j_d = j_q;
		qv_d = qv_q;
		len_d = len_q;
		pos_d = pos_q;
		flush_d = flush_q;
		buf_d = buf_q;
		fill_d = fill_q;
		ov_d = ov_q && !out_ready;
		od_d = od_q;
		if (!busy_q) begin
			if (job_valid) begin
				busy_d = 1'b1;
				j_d = job_data;
				qv_d = qv_in;
				len_d = qv_in + 9'd1 + 9'(job_data.k);
				pos_d = '0;
				flush_d = 1'b0;
			end
		end else if (!stall) begin
			if (flush_q) begin
				// flush step of end item
				busy_d = 1'b0;
				flush_d = 1'b0;
				ov_d = 1'b1;
				od_d.packed_word = buf_q;
				od_d.last_of_item = 1'b1;
				od_d.stream_end = 1'b1;
				buf_d = '0;
				fill_d = '0;
			end else begin
				if (fill_q == 5'd31) begin
					ov_d = 1'b1;
					od_d.packed_word = nbuf;
					od_d.last_of_item = last_word;
					od_d.stream_end = j_q.is_end && last_bit;
					buf_d = '0;
					fill_d = '0;
				end else begin
					buf_d = nbuf;
					fill_d = fill_q + 1'b1;
				end
				pos_d = pos_q + 1'b1;
				if (last_bit) begin
					if (j_q.is_end && fill_q != 5'd31) flush_d = 1'b1;
					else busy_d = 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			flush_q <= 1'b0;
			buf_q <= '0;
			fill_q <= '0;
			ov_q <= 1'b0;
		end else begin
			busy_q <= busy_d;
			flush_q <= flush_d;
			buf_q <= buf_d;
			fill_q <= fill_d;
			ov_q <= ov_d;
		end
	end

	always_ff @(posedge clk) begin
		j_q <= j_d;
		qv_q <= qv_d;
		len_q <= len_d;
		pos_q <= pos_d;
		od_q <= od_d;
	end
endmodule

// File: design/context_rank_golomb_rice_encoder.sv
// context rank golomb rice encoder: the front takes one symbol item at a time, looks up
// its rank, compares list entries toward the list head, then swaps and pushes a job
// the back packs a code bit by bit, flushing the partial word after an end item, and
// takes a new code only when done with the last; output stalls hold the back; the
// slower of the two sets throughput; after reset a clearing pass over all 65536 entries
// runs before the first item is taken; a two-entry job queue sits between front and back
module context_rank_golomb_rice_encoder import crgr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  in_item_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output out_item_t out_data
);
`include "assert_macros.svh"
	logic fv, fr, bv, br;
	job_t fj, bj;
	job_t q_q [QDEPTH];
	logic [1:0] n_q;
	logic rp_q, wp_q;

	crgr_front u_front (.clk, .arst_n, .in_valid, .in_ready, .in_data,
		.job_valid(fv), .job_ready(fr), .job_data(fj));

	assign fr = (n_q != 2'(QDEPTH));
	assign bv = (n_q != 2'd0);
	assign bj = q_q[rp_q];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= '0; rp_q <= 1'b0; wp_q <= 1'b0;
		end else begin
			if (fv && fr) wp_q <= !wp_q;
			if (bv && br) rp_q <= !rp_q;
			n_q <= n_q + 2'(fv && fr) - 2'(bv && br);
		end
	end
	always_ff @(posedge clk) if (fv && fr) q_q[wp_q] <= fj;

	crgr_back u_back (.clk, .arst_n, .job_valid(bv), .job_ready(br), .job_data(bj),
		.out_valid, .out_ready, .out_data);

	`ASSERT_IMPLIES(a_q_bound, clk, arst_n, 1'b1, n_q <= 2'(QDEPTH))
	`ASSERT_IMPLIES(a_end_last, clk, arst_n, out_valid && out_data.stream_end, out_data.last_of_item)
	`ASSERT_NEXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid)
endmodule
